>>> hdl/h264_sps_resolution_parser_unit_defines.svh
// Assertion macros for the checker file of the SPS resolution parser.
`ifndef H264_SPS_RESOLUTION_PARSER_UNIT_DEFINES_SVH
`define H264_SPS_RESOLUTION_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SPSRES_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SPSRES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> hdl/spsres_pkg.sv
// Shared types and constants of the SPS resolution parser.
`default_nettype none

package spsres_pkg;

   localparam int unsigned MAX_LEAD_ZEROS_DEF = 31;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned MBS_W    = 12;
   localparam int unsigned CROP_W   = 15;
   localparam int unsigned SIZE_W   = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned RSP_W    = 40;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TRUNC = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LONG  = 2'd2;

   // One bit handed from the byte feeder to the bit-step unit.
   typedef struct packed {
      logic valid;
      logic value;
   } bit_xfer_type;

   // Parse outcome that the result stage turns into sizes.
   typedef struct packed {
      logic                  done;
      logic [STATUS_W-1:0]   fault;
      logic [MBS_W-1:0]      width_mbs;
      logic [MBS_W-1:0]      height_units;
      logic                  frame_only;
      logic [CROP_W-1:0]     crop_horiz;
      logic [CROP_W-1:0]     crop_vert;
   } parse_info_type;

endpackage

`default_nettype wire

>>> hdl/h264_sps_resolution_parser_unit.sv
// Top level of the H.264 SPS resolution parser.
//
//  Group | Direction | Ports                         | Contents
//  req   | in        | req_tvalid/tready/tdata/tlast | one SPS payload byte, tlast on the final one
//  rsp   | out       | rsp_tvalid/tready/tdata       | cropped width, height and status
//
//  The bit-step unit consumes one bit per cycle while a byte is shifted out, and the
//  next byte of the same unit is taken on the final bit of the current one.
//  After the byte marked last, the feeder waits in its emit state while an earlier
//  result is still waiting to be taken, then loads the result register.
//  Reset is synchronous and clears all parse state; it needs no clearing pass.
//  A stalled result holds in the output register; parsing of the next unit goes on.
`default_nettype none

module h264_sps_resolution_parser_unit
   import spsres_pkg::*;
#(
   parameter int unsigned MAX_LEAD_ZEROS = MAX_LEAD_ZEROS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [BYTE_W-1:0] req_tdata,  // [7:0] data_byte
   input  wire logic              req_tlast,  // last_byte
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata   // [15:0] pic_width, [31:16] pic_height,
                                              // [33:32] status, [39:34] zero
);

   bit_xfer_type   bit_x;
   parse_info_type info;
   logic           emit;
   logic           out_free;

   // Byte holding and bit sequencing.
   spsres_feed u_feed (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .out_free   (out_free),
      .bit_out    (bit_x),
      .emit       (emit)
   );

   // Shared bit-step unit; cleared as the result is captured.
   spsres_parse #(
      .MAX_LEAD_ZEROS (MAX_LEAD_ZEROS)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .clear  (emit),
      .bit_in (bit_x),
      .info   (info)
   );

   // Size computation and output register.
   spsres_result u_result (
      .clock      (clock),
      .reset      (reset),
      .load       (emit),
      .info       (info),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> hdl/spsres_feed.sv
// Byte feeder: holds one accepted byte and shifts it out one bit per cycle.
`default_nettype none

module spsres_feed
   import spsres_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [BYTE_W-1:0] req_tdata,
   input  wire logic              req_tlast,
   input  wire logic              out_free,
   output bit_xfer_type           bit_out,
   output logic                   emit
);

   typedef enum logic [1:0] {
      FD_IDLE,
      FD_SHIFT,
      FD_EMIT
   } feed_state_type;

   localparam logic [2:0] LAST_BIT = 3'(BYTE_W - 1);

   feed_state_type    state_ff, state_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [2:0]        count_ff, count_in;
   logic              last_ff, last_in;
   logic              accept;

   // Ready when idle, or on the final bit of a byte that does not end the unit.
   assign req_tready = (state_ff == FD_IDLE) ||
                       ((state_ff == FD_SHIFT) && (count_ff == LAST_BIT) && !last_ff);
   assign accept     = req_tvalid && req_tready;

   assign bit_out.valid = (state_ff == FD_SHIFT);
   assign bit_out.value = byte_ff[BYTE_W-1];
   assign emit          = (state_ff == FD_EMIT) && out_free;

   // Next-state logic of the feeder.
   always_comb begin
      state_in = state_ff;
      byte_in  = byte_ff;
      count_in = count_ff;
      last_in  = last_ff;
      unique case (state_ff)
         FD_IDLE: begin
            state_in = FD_IDLE;
         end
         FD_SHIFT: begin
            byte_in  = {byte_ff[BYTE_W-2:0], 1'b0};
            count_in = count_ff + 3'd1;
            if (count_ff == LAST_BIT) begin
               state_in = last_ff ? FD_EMIT : FD_IDLE;
            end
         end
         FD_EMIT: begin
            if (out_free) begin
               state_in = FD_IDLE;
            end
         end
         default: begin
            state_in = FD_IDLE;
         end
      endcase
      if (accept) begin
         state_in = FD_SHIFT;
         byte_in  = req_tdata;
         count_in = 3'd0;
         last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FD_IDLE;
         count_ff <= 3'd0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
      byte_ff <= byte_in;
   end

endmodule

`default_nettype wire

>>> hdl/spsres_parse.sv
// Bit-step unit: walks SPS syntax one bit per valid cycle, decoding Exp-Golomb codes.
`default_nettype none

module spsres_parse
   import spsres_pkg::*;
#(
   parameter int unsigned MAX_LEAD_ZEROS = MAX_LEAD_ZEROS_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           clear,
   input  wire bit_xfer_type   bit_in,
   output parse_info_type      info
);

   localparam int unsigned ZC_W  = 6;
   localparam int unsigned VAL_W = 32;

   typedef enum logic [4:0] {
      ST_PROFILE, ST_FLAGS, ST_LEVEL, ST_SPSID, ST_CHROMA, ST_SEPPLANE,
      ST_DEPTHL, ST_DEPTHC, ST_BYPASS, ST_SCALEPRES, ST_SCALELIST, ST_LOG2FN,
      ST_POCTYPE, ST_MAXPOC, ST_DELTA0, ST_OFFNONREF, ST_OFFT2B, ST_NUMREFPOC,
      ST_OFFREF, ST_NUMREF, ST_GAPS, ST_WIDTH, ST_HEIGHT, ST_FRAMEONLY,
      ST_MBAFF, ST_DIRECT, ST_CROPFLAG, ST_CL, ST_CR, ST_CT, ST_CB
   } step_type;

   // Bit count of each fixed-width element; zero marks an Exp-Golomb element.
   function automatic logic [3:0] field_width(input step_type s);
      logic [3:0] w;
      begin
         unique case (s)
            ST_PROFILE, ST_FLAGS, ST_LEVEL: w = 4'd8;
            ST_SEPPLANE, ST_BYPASS, ST_SCALEPRES, ST_SCALELIST, ST_DELTA0,
            ST_GAPS, ST_FRAMEONLY, ST_MBAFF, ST_DIRECT, ST_CROPFLAG: w = 4'd1;
            default: w = 4'd0;
         endcase
         return w;
      end
   endfunction

   // Profiles that carry the chroma and scaling branch.
   function automatic logic high_profile(input logic [BYTE_W-1:0] p);
      return (p == 8'd100) || (p == 8'd110) || (p == 8'd122) || (p == 8'd244) ||
             (p == 8'd44)  || (p == 8'd83)  || (p == 8'd86)  || (p == 8'd118);
   endfunction

   step_type            step_ff, step_in;
   logic [ZC_W-1:0]     zc_ff, zc_in;
   logic [ZC_W-1:0]     left_ff, left_in;
   logic [VAL_W-1:0]    fv_ff, fv_in;
   logic [BYTE_W-1:0]   profile_ff, profile_in;
   logic                c444_ff, c444_in;
   logic [VAL_W-1:0]    loop_ff, loop_in;
   logic [MBS_W-1:0]    mbs_ff, mbs_in;
   logic [MBS_W-1:0]    units_ff, units_in;
   logic                frame_ff, frame_in;
   logic [CROP_W-1:0]   croph_ff, croph_in;
   logic [CROP_W-1:0]   cropv_ff, cropv_in;
   logic                done_ff, done_in;
   logic [STATUS_W-1:0] fault_ff, fault_in;

   logic             is_golomb;
   logic [VAL_W-1:0] fv_shift;
   logic [VAL_W-1:0] gmask;
   logic [VAL_W-1:0] gsum;
   logic [VAL_W-1:0] loop_dec;
   logic             finish;
   logic [VAL_W-1:0] fin_val;
   logic             go;
   step_type         nxt;

   assign is_golomb = (field_width(step_ff) == 4'd0);
   assign fv_shift  = {fv_ff[VAL_W-2:0], bit_in.value};
   // 2^zc - 1 taken mod 2^32: all ones once the prefix reaches 32 zeros.
   assign gmask     = zc_ff[ZC_W-1] ? '1 : ~({VAL_W{1'b1}} << zc_ff[ZC_W-2:0]);
   assign gsum      = fv_shift + gmask;
   assign loop_dec  = loop_ff - 32'd1;

   // One bit of the syntax per valid cycle, with the element hand-off on its last bit.
   always_comb begin
      step_in    = step_ff;
      zc_in      = zc_ff;
      left_in    = left_ff;
      fv_in      = fv_ff;
      profile_in = profile_ff;
      c444_in    = c444_ff;
      loop_in    = loop_ff;
      mbs_in     = mbs_ff;
      units_in   = units_ff;
      frame_in   = frame_ff;
      croph_in   = croph_ff;
      cropv_in   = cropv_ff;
      done_in    = done_ff;
      fault_in   = fault_ff;
      finish     = 1'b0;
      fin_val    = '0;
      go         = 1'b0;
      nxt        = step_ff;

      if (bit_in.valid && !done_ff) begin
         if (is_golomb && (left_ff == '0)) begin
            // Prefix of an Exp-Golomb code.
            if (!bit_in.value) begin
               if (zc_ff >= ZC_W'(MAX_LEAD_ZEROS)) begin
                  fault_in = STATUS_LONG;
                  done_in  = 1'b1;
               end else begin
                  zc_in = zc_ff + 6'd1;
               end
            end else if (zc_ff == '0) begin
               finish = 1'b1;
            end else begin
               left_in = zc_ff;
            end
         end else begin
            fv_in   = fv_shift;
            left_in = left_ff - 6'd1;
            if (left_ff == 6'd1) begin
               finish  = 1'b1;
               fin_val = is_golomb ? gsum : fv_shift;
            end
         end
      end

      // Element complete: record what it sets and pick the next element.
      if (finish) begin
         go = 1'b1;
         unique case (step_ff)
            ST_PROFILE: begin
               profile_in = fin_val[BYTE_W-1:0];
               nxt        = ST_FLAGS;
            end
            ST_FLAGS:  nxt = ST_LEVEL;
            ST_LEVEL:  nxt = ST_SPSID;
            ST_SPSID:  nxt = high_profile(profile_ff) ? ST_CHROMA : ST_LOG2FN;
            ST_CHROMA: begin
               c444_in = (fin_val == 32'd3);
               nxt     = (fin_val == 32'd3) ? ST_SEPPLANE : ST_DEPTHL;
            end
            ST_SEPPLANE: nxt = ST_DEPTHL;
            ST_DEPTHL:   nxt = ST_DEPTHC;
            ST_DEPTHC:   nxt = ST_BYPASS;
            ST_BYPASS:   nxt = ST_SCALEPRES;
            ST_SCALEPRES: begin
               if (fin_val != '0) begin
                  loop_in = c444_ff ? 32'd12 : 32'd8;
                  nxt     = ST_SCALELIST;
               end else begin
                  nxt = ST_LOG2FN;
               end
            end
            ST_SCALELIST: begin
               loop_in = loop_dec;
               nxt     = (loop_dec == '0) ? ST_LOG2FN : ST_SCALELIST;
            end
            ST_LOG2FN: nxt = ST_POCTYPE;
            ST_POCTYPE: begin
               if (fin_val == '0) begin
                  nxt = ST_MAXPOC;
               end else if (fin_val == 32'd1) begin
                  nxt = ST_DELTA0;
               end else begin
                  nxt = ST_NUMREF;
               end
            end
            ST_MAXPOC:    nxt = ST_NUMREF;
            ST_DELTA0:    nxt = ST_OFFNONREF;
            ST_OFFNONREF: nxt = ST_OFFT2B;
            ST_OFFT2B:    nxt = ST_NUMREFPOC;
            ST_NUMREFPOC: begin
               loop_in = fin_val;
               nxt     = (fin_val == '0) ? ST_NUMREF : ST_OFFREF;
            end
            ST_OFFREF: begin
               loop_in = loop_dec;
               nxt     = (loop_dec == '0) ? ST_NUMREF : ST_OFFREF;
            end
            ST_NUMREF: nxt = ST_GAPS;
            ST_GAPS:   nxt = ST_WIDTH;
            ST_WIDTH: begin
               mbs_in = fin_val[MBS_W-1:0];
               nxt    = ST_HEIGHT;
            end
            ST_HEIGHT: begin
               units_in = fin_val[MBS_W-1:0];
               nxt      = ST_FRAMEONLY;
            end
            ST_FRAMEONLY: begin
               frame_in = fin_val[0];
               nxt      = fin_val[0] ? ST_DIRECT : ST_MBAFF;
            end
            ST_MBAFF:  nxt = ST_DIRECT;
            ST_DIRECT: nxt = ST_CROPFLAG;
            ST_CROPFLAG: begin
               if (fin_val != '0) begin
                  nxt = ST_CL;
               end else begin
                  croph_in = '0;
                  cropv_in = '0;
                  done_in  = 1'b1;
                  go       = 1'b0;
               end
            end
            ST_CL: begin
               croph_in = fin_val[CROP_W-1:0];
               nxt      = ST_CR;
            end
            ST_CR: begin
               croph_in = croph_ff + fin_val[CROP_W-1:0];
               nxt      = ST_CT;
            end
            ST_CT: begin
               cropv_in = fin_val[CROP_W-1:0];
               nxt      = ST_CB;
            end
            ST_CB: begin
               cropv_in = cropv_ff + fin_val[CROP_W-1:0];
               done_in  = 1'b1;
               go       = 1'b0;
            end
            default: begin
               done_in = 1'b1;
               go      = 1'b0;
            end
         endcase
      end

      // Start of a new element.
      if (go) begin
         step_in = nxt;
         left_in = ZC_W'(field_width(nxt));
         zc_in   = '0;
         fv_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         step_ff    <= ST_PROFILE;
         zc_ff      <= '0;
         left_ff    <= ZC_W'(field_width(ST_PROFILE));
         fv_ff      <= '0;
         profile_ff <= '0;
         c444_ff    <= 1'b0;
         loop_ff    <= '0;
         mbs_ff     <= '0;
         units_ff   <= '0;
         frame_ff   <= 1'b0;
         croph_ff   <= '0;
         cropv_ff   <= '0;
         done_ff    <= 1'b0;
         fault_ff   <= STATUS_OK;
      end else begin
         step_ff    <= step_in;
         zc_ff      <= zc_in;
         left_ff    <= left_in;
         fv_ff      <= fv_in;
         profile_ff <= profile_in;
         c444_ff    <= c444_in;
         loop_ff    <= loop_in;
         mbs_ff     <= mbs_in;
         units_ff   <= units_in;
         frame_ff   <= frame_in;
         croph_ff   <= croph_in;
         cropv_ff   <= cropv_in;
         done_ff    <= done_in;
         fault_ff   <= fault_in;
      end
   end

   assign info.done         = done_ff;
   assign info.fault        = fault_ff;
   assign info.width_mbs    = mbs_ff;
   assign info.height_units = units_ff;
   assign info.frame_only   = frame_ff;
   assign info.crop_horiz   = croph_ff;
   assign info.crop_vert    = cropv_ff;

endmodule

`default_nettype wire

>>> hdl/spsres_result.sv
// Result stage: turns the parse outcome into sizes and status and holds the transfer.
`default_nettype none

module spsres_result
   import spsres_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire parse_info_type   info,
   output logic                  out_free,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata
);

   localparam int unsigned PAD_W = RSP_W - 2 * SIZE_W - STATUS_W;

   logic                valid_ff, valid_in;
   logic [RSP_W-1:0]    data_ff, data_in;
   logic [STATUS_W-1:0] status;
   logic [MBS_W-1:0]    mbs_inc;
   logic [MBS_W-1:0]    units_inc;
   logic [SIZE_W-1:0]   base_h;
   logic [SIZE_W-1:0]   width;
   logic [SIZE_W-1:0]   height;

   assign out_free = !valid_ff || rsp_tready;

   // Status: a long code wins over a short payload.
   always_comb begin
      priority if (info.fault == STATUS_LONG) begin
         status = STATUS_LONG;
      end else if (!info.done) begin
         status = STATUS_TRUNC;
      end else begin
         status = STATUS_OK;
      end
   end

   // Sizes mod 65536: only the low bits of counts and crops reach the result.
   assign mbs_inc   = info.width_mbs + 12'd1;
   assign units_inc = info.height_units + 12'd1;
   assign base_h    = info.frame_only ? {units_inc, 4'b0} : {units_inc[MBS_W-2:0], 5'b0};
   assign width     = {mbs_inc, 4'b0} - {info.crop_horiz, 1'b0};
   assign height    = base_h - {info.crop_vert, 1'b0};

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = (status == STATUS_OK) ?
                    {{PAD_W{1'b0}}, status, height, width} :
                    {{PAD_W{1'b0}}, status, {(2 * SIZE_W){1'b0}}};
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

>>> hdl/spsres_checker.sv
// Port-level checks of the SPS resolution parser and their binding to the top level.
`default_nettype none
`include "h264_sps_resolution_parser_unit_defines.svh"

module spsres_port_checker
   import spsres_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [RSP_W-1:0]  rsp_tdata
);

   logic               req_xfer;
   logic               rsp_hold;
   logic               status_bad;
   logic               status_fail;

   assign req_xfer    = req_tvalid && req_tready;
   assign rsp_hold    = rsp_tvalid && !rsp_tready;
   assign status_bad  = (rsp_tdata[33:32] > STATUS_LONG) || (rsp_tdata[RSP_W-1:34] != '0);
   assign status_fail = (rsp_tdata[33:32] != STATUS_OK);

   // A result that is not taken stays offered, unchanged.
   `SPSRES_ASSERT_NEXT(a_rsp_hold_valid, clock, reset, rsp_hold, rsp_tvalid)
   `SPSRES_ASSERT_NEXT(a_rsp_hold_data, clock, reset, rsp_hold, $stable(rsp_tdata))

   // Status is a legal code and the padding stays zero.
   `SPSRES_ASSERT_NOW(a_status_legal, clock, reset, rsp_tvalid, !status_bad)

   // A failed parse reports no picture size.
   `SPSRES_ASSERT_NOW(a_fail_zero, clock, reset, rsp_tvalid && status_fail,
                      rsp_tdata[31:0] == 32'd0)

   // Each byte is worked bit by bit, so the input closes right after a transfer.
   `SPSRES_ASSERT_NEXT(a_busy_after_xfer, clock, reset, req_xfer, !req_tready)

endmodule

bind h264_sps_resolution_parser_unit spsres_port_checker u_checker (.*);

`default_nettype wire
